// ----- rtl/assert_macros.svh -----
// Assertion macros used by the vector normalizer RTL.
// Depends on the including module providing i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/vn_pkg.sv -----
// Types and constants for the vector normalizer.
// No dependencies.
package vn_pkg;

    localparam int unsigned SQ_STAGES  = 24;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned DIV_LAT    = DIV_STEPS + 2;

    typedef struct packed {
        logic signed [15:0] x_in;
        logic signed [15:0] y_in;
        logic signed [15:0] z_in;
    } t_vn_in;

    typedef struct packed {
        logic        [23:0] magnitude;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               zero_vector;
    } t_vn_out;

    localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q15_MIN = 16'sh8000;

endpackage

// ----- rtl/vn_sqrt.sv -----
// Pipelined integer square root of sum << 16, one result bit per stage.
// Depends on vn_pkg.
module vn_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [31:0] i_sum,
    output logic        o_vld,
    output logic [23:0] o_root
);
    import vn_pkg::*;

    logic        r_vld  [SQ_STAGES];
    logic [24:0] r_rem  [SQ_STAGES];
    logic [23:0] r_root [SQ_STAGES];
    logic [31:0] r_v    [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        logic        w_vld;
        logic [24:0] w_rem;
        logic [23:0] w_root;
        logic [31:0] w_v;
        logic [26:0] w_cur;
        logic [26:0] w_trial;
        logic [24:0] n_rem;
        logic [23:0] n_root;

        if (g == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_v    = i_sum;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_v    = r_v[g-1];
        end

        // bring down the next two radicand bits; zeros once the sum is used up
        always_comb begin
            w_cur   = {w_rem, w_v[31:30]};
            w_trial = {1'b0, w_root, 2'b01};
            if (w_cur >= w_trial) begin
                n_rem  = 25'(w_cur - w_trial);
                n_root = {w_root[22:0], 1'b1};
            end else begin
                n_rem  = w_cur[24:0];
                n_root = {w_root[22:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
            r_rem[g]  <= n_rem;
            r_root[g] <= n_root;
            r_v[g]    <= {w_v[29:0], 2'b00};
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_root = r_root[SQ_STAGES-1];

endmodule

// ----- rtl/vn_div.sv -----
// Pipelined restoring divider: (a << 23) / mag with Q1.15 saturation and sign.
// Depends on vn_pkg.
module vn_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic        [15:0] i_a,
    input  logic               i_neg,
    input  logic        [23:0] i_mag,
    output logic               o_vld,
    output logic signed [15:0] o_q
);
    import vn_pkg::*;

    logic        r_p_vld;
    logic [23:0] r_p_rem;
    logic [23:0] r_p_mag;
    logic        r_p_neg;
    logic        r_p_ovf;

    logic        r_vld [DIV_STEPS];
    logic [23:0] r_rem [DIV_STEPS];
    logic [15:0] r_q   [DIV_STEPS];
    logic [23:0] r_mag [DIV_STEPS];
    logic        r_neg [DIV_STEPS];
    logic        r_ovf [DIV_STEPS];

    logic               r_o_vld;
    logic signed [15:0] r_o_q;

    logic [23:0] w_a7;
    logic        w_ovf;
    assign w_a7  = {1'b0, i_a, 7'b0};
    // quotient reaches 2^16 exactly when (a << 7) >= mag
    assign w_ovf = (w_a7 >= i_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
        end
        r_p_rem <= w_ovf ? '0 : w_a7;
        r_p_mag <= i_mag;
        r_p_neg <= i_neg;
        r_p_ovf <= w_ovf;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic        w_vld;
        logic [23:0] w_rem;
        logic [15:0] w_q;
        logic [23:0] w_mag;
        logic        w_neg;
        logic        w_ovf_s;
        logic [24:0] w_cur;
        logic [23:0] n_rem;
        logic        n_bit;

        if (g == 0) begin : g_first
            assign w_vld   = r_p_vld;
            assign w_rem   = r_p_rem;
            assign w_q     = '0;
            assign w_mag   = r_p_mag;
            assign w_neg   = r_p_neg;
            assign w_ovf_s = r_p_ovf;
        end else begin : g_next
            assign w_vld   = r_vld[g-1];
            assign w_rem   = r_rem[g-1];
            assign w_q     = r_q[g-1];
            assign w_mag   = r_mag[g-1];
            assign w_neg   = r_neg[g-1];
            assign w_ovf_s = r_ovf[g-1];
        end

        always_comb begin
            w_cur = {w_rem, 1'b0};
            if (w_cur >= {1'b0, w_mag}) begin
                n_rem = 24'(w_cur - {1'b0, w_mag});
                n_bit = 1'b1;
            end else begin
                n_rem = w_cur[23:0];
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
            r_rem[g] <= n_rem;
            r_q[g]   <= {w_q[14:0], n_bit};
            r_mag[g] <= w_mag;
            r_neg[g] <= w_neg;
            r_ovf[g] <= w_ovf_s;
        end
    end

    logic [15:0]        w_qf;
    logic               w_neg_f;
    logic               w_ovf_f;
    logic signed [15:0] n_o_q;
    assign w_qf    = r_q[DIV_STEPS-1];
    assign w_neg_f = r_neg[DIV_STEPS-1];
    assign w_ovf_f = r_ovf[DIV_STEPS-1];

    always_comb begin
        if (w_neg_f) begin
            if (w_ovf_f || (w_qf > 16'h8000)) begin
                n_o_q = Q15_MIN;
            end else begin
                n_o_q = 16'sh0 - $signed(w_qf);
            end
        end else begin
            if (w_ovf_f || w_qf[15]) begin
                n_o_q = Q15_MAX;
            end else begin
                n_o_q = $signed(w_qf);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_vld[DIV_STEPS-1];
        end
        r_o_q <= n_o_q;
    end

    assign o_vld = r_o_vld;
    assign o_q   = r_o_q;

endmodule

// ----- rtl/vector3_normalize_top.sv -----
// Vector normalizer: Q16.8 length and Q1.15 unit vector of a 3-axis sample.
// Pipeline from accept to strobe: input, square and sum stages,
// 24 square-root stages (one root bit each), 18 divider stages.
// Throughput one item per clock; busy stays low since the receiver cannot stall.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module vector3_normalize_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  vn_pkg::t_vn_in   i_in,
    output logic             o_strobe,
    output vn_pkg::t_vn_out  o_res
);
    import vn_pkg::*;
    `include "assert_macros.svh"

    logic w_accept;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // stage 0: capture
    logic               r0_vld;
    logic signed [15:0] r0_x, r0_y, r0_z;
    // stage 1: squares
    logic               r1_vld;
    logic        [31:0] r1_xx, r1_yy, r1_zz;
    logic signed [15:0] r1_x, r1_y, r1_z;
    // stage 2: sum
    logic               r2_vld;
    logic        [31:0] r2_sum;
    logic signed [15:0] r2_x, r2_y, r2_z;

    logic signed [31:0] w_xx, w_yy, w_zz;
    assign w_xx = r0_x * r0_x;
    assign w_yy = r0_y * r0_y;
    assign w_zz = r0_z * r0_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r0_vld <= w_accept;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
        r0_x   <= i_in.x_in;
        r0_y   <= i_in.y_in;
        r0_z   <= i_in.z_in;
        r1_xx  <= $unsigned(w_xx);
        r1_yy  <= $unsigned(w_yy);
        r1_zz  <= $unsigned(w_zz);
        r1_x   <= r0_x;
        r1_y   <= r0_y;
        r1_z   <= r0_z;
        r2_sum <= r1_xx + r1_yy + r1_zz;
        r2_x   <= r1_x;
        r2_y   <= r1_y;
        r2_z   <= r1_z;
    end

    logic        w_sq_vld;
    logic [23:0] w_root;

    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_sum   (r2_sum),
        .o_vld   (w_sq_vld),
        .o_root  (w_root)
    );

    // hold components alongside the root pipeline
    logic signed [15:0] r_cd_x [SQ_STAGES];
    logic signed [15:0] r_cd_y [SQ_STAGES];
    logic signed [15:0] r_cd_z [SQ_STAGES];
    logic               r_cd_zero [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        r_cd_x[0]    <= r2_x;
        r_cd_y[0]    <= r2_y;
        r_cd_z[0]    <= r2_z;
        r_cd_zero[0] <= (r2_sum == 32'd0);
        for (int i = 1; i < SQ_STAGES; i++) begin
            r_cd_x[i]    <= r_cd_x[i-1];
            r_cd_y[i]    <= r_cd_y[i-1];
            r_cd_z[i]    <= r_cd_z[i-1];
            r_cd_zero[i] <= r_cd_zero[i-1];
        end
    end

    logic signed [15:0] w_cx, w_cy, w_cz;
    assign w_cx = r_cd_x[SQ_STAGES-1];
    assign w_cy = r_cd_y[SQ_STAGES-1];
    assign w_cz = r_cd_z[SQ_STAGES-1];

    logic [15:0] w_ax, w_ay, w_az;
    assign w_ax = w_cx[15] ? 16'(-w_cx) : 16'(w_cx);
    assign w_ay = w_cy[15] ? 16'(-w_cy) : 16'(w_cy);
    assign w_az = w_cz[15] ? 16'(-w_cz) : 16'(w_cz);

    logic               w_dx_vld, w_dy_vld, w_dz_vld;
    logic signed [15:0] w_ux, w_uy, w_uz;

    vn_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (w_sq_vld),
        .i_a (w_ax), .i_neg (w_cx[15]), .i_mag (w_root),
        .o_vld (w_dx_vld), .o_q (w_ux)
    );
    vn_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (w_sq_vld),
        .i_a (w_ay), .i_neg (w_cy[15]), .i_mag (w_root),
        .o_vld (w_dy_vld), .o_q (w_uy)
    );
    vn_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (w_sq_vld),
        .i_a (w_az), .i_neg (w_cz[15]), .i_mag (w_root),
        .o_vld (w_dz_vld), .o_q (w_uz)
    );

    // hold magnitude and zero flag alongside the dividers
    logic [23:0] r_md_mag  [DIV_LAT];
    logic        r_md_zero [DIV_LAT];
    logic        r_md_vld  [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_md_vld[i] <= 1'b0;
            end
        end else begin
            r_md_vld[0] <= w_sq_vld;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_md_vld[i] <= r_md_vld[i-1];
            end
        end
        r_md_mag[0]  <= w_root;
        r_md_zero[0] <= r_cd_zero[SQ_STAGES-1];
        for (int i = 1; i < DIV_LAT; i++) begin
            r_md_mag[i]  <= r_md_mag[i-1];
            r_md_zero[i] <= r_md_zero[i-1];
        end
    end

    logic w_zero;
    assign w_zero   = r_md_zero[DIV_LAT-1];
    assign o_strobe = w_dx_vld;

    // drop divider results for a zero vector
    always_comb begin
        o_res.zero_vector = w_zero;
        o_res.magnitude   = w_zero ? 24'd0 : r_md_mag[DIV_LAT-1];
        o_res.unit_x      = w_zero ? 16'sd0 : w_ux;
        o_res.unit_y      = w_zero ? 16'sd0 : w_uy;
        o_res.unit_z      = w_zero ? 16'sd0 : w_uz;
    end

    `ASSERT_NEVER(a_lane_align, (w_dx_vld != r_md_vld[DIV_LAT-1]) || (w_dx_vld != w_dy_vld) || (w_dx_vld != w_dz_vld), "divider lanes out of step with magnitude delay")
    `ASSERT_IMPL(a_mag_floor, o_strobe && !w_zero, r_md_mag[DIV_LAT-1] >= 24'd256, "nonzero vector with length below one")
    `ASSERT_NEVER(a_zero_root, r_cd_zero[SQ_STAGES-1] && w_sq_vld && (w_root != 24'd0), "zero vector with nonzero root")

endmodule
